// ----- rtl/core/fpr_pkg.sv -----
// Shared types, constants and microcode table of the FIFO page replacement unit.
package fpr_pkg;

  // Fixed port field widths
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned FRAME_IDX_W = 4;
  localparam int unsigned FAULT_W     = 16;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 2;

  // Reset value of the frame count register
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Saturation value of the fault counter
  localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

  // Microprogram step codes
  localparam int unsigned STEP_W = 2;
  localparam logic [STEP_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STEP_W-1:0] ST_SCAN = 2'd1;
  localparam logic [STEP_W-1:0] ST_HIT  = 2'd2;
  localparam logic [STEP_W-1:0] ST_MISS = 2'd3;

  // Branch condition codes
  localparam int unsigned COND_W = 3;
  localparam logic [COND_W-1:0] COND_NEVER  = 3'd0;
  localparam logic [COND_W-1:0] COND_START  = 3'd1;
  localparam logic [COND_W-1:0] COND_MATCH  = 3'd2;
  localparam logic [COND_W-1:0] COND_LAST   = 3'd3;
  localparam logic [COND_W-1:0] COND_ALWAYS = 3'd4;

  // One control word of the microprogram
  typedef struct packed {
    logic              load_page;  // latch the reference, rewind the scan index
    logic              scan;       // compare one frame and step the index
    logic              emit;       // present a result
    logic              fault;      // replace the oldest frame
    logic [COND_W-1:0] br_cond;    // first branch, highest priority
    logic [STEP_W-1:0] br_tgt;
    logic [COND_W-1:0] br2_cond;   // second branch
    logic [STEP_W-1:0] br2_tgt;
    logic [STEP_W-1:0] seq_tgt;    // fall-through step
  } ctrl_word_t;

  // Datapath status fed back to the sequencer
  typedef struct packed {
    logic match;  // frame under the scan index holds the page
    logic last;   // scan index sits on the last active frame
  } dp_status_t;

  // Microcode table
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.load_page = 1'b1;
        w.br_cond   = COND_START;
        w.br_tgt    = ST_SCAN;
        w.br2_cond  = COND_NEVER;
        w.br2_tgt   = ST_IDLE;
        w.seq_tgt   = ST_IDLE;
      end
      ST_SCAN: begin
        w.scan     = 1'b1;
        w.br_cond  = COND_MATCH;
        w.br_tgt   = ST_HIT;
        w.br2_cond = COND_LAST;
        w.br2_tgt  = ST_MISS;
        w.seq_tgt  = ST_SCAN;
      end
      ST_HIT: begin
        w.emit    = 1'b1;
        w.br_cond = COND_ALWAYS;
        w.br_tgt  = ST_IDLE;
        w.seq_tgt = ST_IDLE;
      end
      ST_MISS: begin
        w.emit    = 1'b1;
        w.fault   = 1'b1;
        w.br_cond = COND_ALWAYS;
        w.br_tgt  = ST_IDLE;
        w.seq_tgt = ST_IDLE;
      end
      default: begin
        w.br_cond = COND_ALWAYS;
        w.br_tgt  = ST_IDLE;
        w.seq_tgt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/fpr_seq.sv -----
// Microcode sequencer: step counter, control store and branch logic.
module fpr_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fpr_pkg::dp_status_t status_i,
  output fpr_pkg::ctrl_word_t ctrl_o,
  output logic                busy_o
);

  logic [fpr_pkg::STEP_W-1:0] step_r;
  logic [fpr_pkg::STEP_W-1:0] step_nxt;
  fpr_pkg::ctrl_word_t        rom_word;
  logic                       br_take;
  logic                       br2_take;

  // Fetch the control word of the current step
  assign rom_word = fpr_pkg::ucode_rom(step_r);

  // Evaluate one branch condition
  function automatic logic cond_true(input logic [fpr_pkg::COND_W-1:0] c,
                                     input logic st,
                                     input fpr_pkg::dp_status_t s);
    logic r;
    r = 1'b0;
    unique case (c)
      fpr_pkg::COND_NEVER:  r = 1'b0;
      fpr_pkg::COND_START:  r = st;
      fpr_pkg::COND_MATCH:  r = s.match;
      fpr_pkg::COND_LAST:   r = s.last;
      fpr_pkg::COND_ALWAYS: r = 1'b1;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  assign br_take  = cond_true(rom_word.br_cond, start, status_i);
  assign br2_take = cond_true(rom_word.br2_cond, start, status_i);

  // Pick the next step
  always_comb begin
    if (br_take) begin
      step_nxt = rom_word.br_tgt;
    end else if (br2_take) begin
      step_nxt = rom_word.br2_tgt;
    end else begin
      step_nxt = rom_word.seq_tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fpr_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Gate the reference load with the start transfer
  always_comb begin
    ctrl_o           = rom_word;
    ctrl_o.load_page = rom_word.load_page & start;
  end

  assign busy_o = (step_r != fpr_pkg::ST_IDLE);

  // A matching frame ends the scan with a hit
  a_match_to_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == fpr_pkg::ST_SCAN) && status_i.match |=> (step_r == fpr_pkg::ST_HIT))
    else $error("scan match did not branch to hit step");

  // The last frame without a match ends the scan with a fault
  a_last_to_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == fpr_pkg::ST_SCAN) && !status_i.match && status_i.last
      |=> (step_r == fpr_pkg::ST_MISS))
    else $error("scan end did not branch to miss step");

  // Every result step returns to idle
  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == fpr_pkg::ST_HIT) || (step_r == fpr_pkg::ST_MISS)
      |=> (step_r == fpr_pkg::ST_IDLE))
    else $error("result step did not return to idle");

endmodule

// ----- rtl/core/fpr_datapath.sv -----
// Datapath: frame page memory, valid bits, scan index, oldest pointer, fault counter.
module fpr_datapath #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fpr_pkg::ctrl_word_t              ctrl_i,
  input  logic                             clear_i,
  input  logic [fpr_pkg::CFG_W-1:0]        frames_i,
  input  logic [fpr_pkg::PAGE_W-1:0]       page_i,
  output fpr_pkg::dp_status_t              status_o,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [fpr_pkg::FRAME_IDX_W-1:0]  out_frame_index,
  output logic [fpr_pkg::FAULT_W-1:0]      out_fault_count
);

  localparam int unsigned PW = (PAGE_BITS < fpr_pkg::PAGE_W) ? PAGE_BITS : fpr_pkg::PAGE_W;
  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW = (NW > fpr_pkg::CFG_W) ? NW : fpr_pkg::CFG_W;
  localparam int unsigned XW = FW + fpr_pkg::FRAME_IDX_W;

  logic [PW-1:0]                    page_mem [MAX_FRAMES];
  logic [PW-1:0]                    rd_data_r;
  logic [PW-1:0]                    page_r;
  logic [FW-1:0]                    idx_r;
  logic [FW-1:0]                    idx_nxt;
  logic [MAX_FRAMES-1:0]            valid_r;
  logic [FW-1:0]                    ptr_r;
  logic [FW-1:0]                    slot;
  logic [fpr_pkg::FAULT_W-1:0]      fault_r;
  logic [fpr_pkg::FAULT_W-1:0]      fault_nxt;
  logic [CW-1:0]                    cfg_ext;
  logic [CW-1:0]                    n_act;
  logic [FW-1:0]                    last_idx;
  logic [FW-1:0]                    res_idx;
  logic [XW-1:0]                    res_ext;
  logic                             out_valid_r;
  logic                             out_hit_r;
  logic [fpr_pkg::FRAME_IDX_W-1:0]  out_frame_r;
  logic [fpr_pkg::FAULT_W-1:0]      out_fault_r;

  // Clamp the frame count to one..MAX_FRAMES
  assign cfg_ext = CW'(frames_i);
  always_comb begin
    if (cfg_ext == '0) begin
      n_act = CW'(1);
    end else if (cfg_ext > CW'(MAX_FRAMES)) begin
      n_act = CW'(MAX_FRAMES);
    end else begin
      n_act = cfg_ext;
    end
  end
  assign last_idx = FW'(n_act - CW'(1));

  // Compare the frame under the scan index
  assign status_o.match = valid_r[idx_r] && (rd_data_r == page_r);
  assign status_o.last  = (idx_r == last_idx);

  // Rewind on load, step while scanning without a decision
  always_comb begin
    idx_nxt = idx_r;
    if (ctrl_i.load_page) begin
      idx_nxt = '0;
    end else if (ctrl_i.scan && !status_o.match && !status_o.last) begin
      idx_nxt = idx_r + FW'(1);
    end
  end

  // Victim frame, wrapping a stale pointer to zero
  assign slot = (CW'(ptr_r) >= n_act) ? '0 : ptr_r;

  // Saturate the fault counter
  assign fault_nxt = (fault_r != fpr_pkg::FAULT_MAX) ? fault_r + 1'b1 : fault_r;

  // Frame page memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl_i.fault) begin
      page_mem[slot] <= page_r;
    end
    rd_data_r <= page_mem[idx_nxt];
  end

  // Hold the reference and the scan index
  always_ff @(posedge clk) begin
    if (ctrl_i.load_page) begin
      page_r <= page_i[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Replacement state: valid bits, oldest pointer, fault counter
  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      valid_r <= '0;
      ptr_r   <= '0;
      fault_r <= '0;
    end else if (ctrl_i.fault) begin
      valid_r[slot] <= 1'b1;
      ptr_r         <= (slot == last_idx) ? '0 : slot + FW'(1);
      fault_r       <= fault_nxt;
    end
  end

  // Result frame, masked to the output width
  assign res_idx = ctrl_i.fault ? slot : idx_r;
  assign res_ext = {{fpr_pkg::FRAME_IDX_W{1'b0}}, res_idx};

  // Result registers: one strobe cycle per reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.emit) begin
      out_hit_r   <= !ctrl_i.fault;
      out_frame_r <= res_ext[fpr_pkg::FRAME_IDX_W-1:0];
      out_fault_r <= ctrl_i.fault ? fault_nxt : fault_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_frame_r;
  assign out_fault_count = out_fault_r;

  // The oldest pointer never leaves the active frames
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(ptr_r) < n_act)
    else $error("oldest pointer beyond active frame count");

  // A fault result always reports a nonzero fault total
  a_fault_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> (out_fault_r != '0))
    else $error("fault result with zero fault count");

  // A fault marks its frame valid
  a_fault_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.fault && !clear_i |=> valid_r[$past(slot)])
    else $error("replaced frame not marked valid");

endmodule

// ----- rtl/core/fifo_page_replacement.sv -----
// Top level of the FIFO page replacement unit: APB register, sequencer and datapath.
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+------------------------------------
//  input    | start, busy, in_page_number             | edge with start high and busy low
//  result   | out_valid, out_hit, out_frame_index,    | out_valid high for one cycle,
//           | out_fault_count                         | taken at the edge ending it
//  config   | psel, penable, pwrite, paddr, pwdata,   | edge with psel, penable, pwrite,
//           | prdata, pready                          | pready high
//
// A reference scans the active frames from frame 0 up to a hit or the last active frame;
// the scan reads one frame per cycle from the single read port of the frame page memory.
// The result strobe rises in the cycle busy falls, so the next start can overlap it.
// Reset (synchronous, rst_n low) empties all frames and sets the frame count to 16.
// Results cannot be stalled; writing the frame count also empties every frame.
module fifo_page_replacement #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                start,
  output logic                                busy,
  input  logic [fpr_pkg::PAGE_W-1:0]          in_page_number,
  // Result channel
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [fpr_pkg::FRAME_IDX_W-1:0]     out_frame_index,
  output logic [fpr_pkg::FAULT_W-1:0]         out_fault_count,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fpr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fpr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [fpr_pkg::CFG_W-1:0] frames_r;
  logic                      cfg_wr;
  fpr_pkg::ctrl_word_t       ctrl;
  fpr_pkg::dp_status_t       status;

  // Frame count register; its single word covers the whole address range
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= fpr_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      frames_r <= pwdata[fpr_pkg::CFG_W-1:0];
    end
  end

  assign prdata = {{(fpr_pkg::APB_DATA_W - fpr_pkg::CFG_W){1'b0}}, frames_r}
                  & {fpr_pkg::APB_DATA_W{paddr == '0 || paddr != '0}};

  fpr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  fpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl_i          (ctrl),
    .clear_i         (cfg_wr),
    .frames_i        (frames_r),
    .page_i          (in_page_number),
    .status_o        (status),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_frame_index (out_frame_index),
    .out_fault_count (out_fault_count)
  );

endmodule

// ----- test/fifo_page_replacement_checker.sv -----
// Result checker of the FIFO page replacement unit: predicts every lookup and compares it.
`timescale 1ns / 1ps
module fifo_page_replacement_checker #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [fpr_pkg::PAGE_W-1:0]          in_page_number,
  input  logic                                out_valid,
  input  logic                                out_hit,
  input  logic [fpr_pkg::FRAME_IDX_W-1:0]     out_frame_index,
  input  logic [fpr_pkg::FAULT_W-1:0]         out_fault_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fpr_pkg::APB_DATA_W-1:0]      pwdata,
  input  logic                                pready,
  output int                                  mismatches,
  output int                                  pending
);
  import fpr_pkg::*;

  localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR  = '0;
  localparam int unsigned           REPORT_LIMIT = 10;
  localparam logic [PAGE_W-1:0]     PAGE_MASK    =
    (PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((1 << PAGE_BITS) - 1);

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic [FAULT_W-1:0]     faults;
  } lookup_t;

  lookup_t              lookup_q[$];
  logic [CFG_W-1:0]     frame_count;
  logic [PAGE_W-1:0]    resident_page [MAX_FRAMES];
  logic                 resident_valid [MAX_FRAMES];
  int unsigned          oldest_frame;
  logic [FAULT_W-1:0]   fault_total;
  int                   fail_cnt = 0;
  int                   waiting_cnt = 0;

  assign mismatches = fail_cnt;
  assign pending    = waiting_cnt;

  // Zero and oversized counts fold into 1..MAX_FRAMES
  function automatic int unsigned active_frames();
    int unsigned n;
    n = frame_count;
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  function automatic void clear_frames();
    foreach (resident_valid[i]) begin
      resident_valid[i] = 1'b0;
      resident_page[i]  = '0;
    end
    oldest_frame = 0;
    fault_total  = '0;
  endfunction

  // Look the page up; on a fault replace the oldest frame and advance the pointer
  function automatic lookup_t predict_lookup(input logic [PAGE_W-1:0] page_in);
    lookup_t           res;
    logic [PAGE_W-1:0] page;
    int unsigned       n;
    int unsigned       slot;
    bit                found;
    page  = page_in & PAGE_MASK;
    n     = active_frames();
    slot  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && resident_valid[i] && resident_page[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (!found) begin
      if (oldest_frame >= n) oldest_frame = 0;
      slot                 = oldest_frame;
      resident_page[slot]  = page;
      resident_valid[slot] = 1'b1;
      oldest_frame         = (oldest_frame + 1 >= n) ? 0 : oldest_frame + 1;
      if (fault_total != FAULT_MAX) fault_total = fault_total + 1'b1;
    end
    res.hit    = found;
    res.frame  = FRAME_IDX_W'(slot);
    res.faults = fault_total;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input lookup_t want, input lookup_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT)
      $display("%0t: %s: expected hit=%0b frame=%0d faults=%0d, got hit=%0b frame=%0d faults=%0d",
               $time, what, want.hit, want.frame, want.faults, got.hit, got.frame, got.faults);
  endtask

  // Compare results, track register writes, predict accepted references
  always @(posedge clk) begin : track
    lookup_t got;
    lookup_t want;
    if (!rst_n) begin
      frame_count = FRAMES_RESET;
      clear_frames();
      lookup_q.delete();
    end else begin
      if (out_valid) begin
        got = {out_hit, out_frame_index, out_fault_count};
        if (lookup_q.size() == 0) begin
          report_mismatch("result with no reference outstanding", lookup_t'('0), got);
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit || got.frame !== want.frame || got.faults !== want.faults)
            report_mismatch("wrong result", want, got);
        end
      end
      if (psel && penable && pwrite && pready && paddr == FRAMES_ADDR) begin
        frame_count = pwdata[CFG_W-1:0];
        clear_frames();
      end
      if (start && !busy) lookup_q.push_back(predict_lookup(in_page_number));
    end
    waiting_cnt <= lookup_q.size();
  end

endmodule

// ----- test/fifo_page_replacement_tb.sv -----
// Testbench top of the FIFO page replacement unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fifo_page_replacement_tb;
  import fpr_pkg::*;

  localparam int unsigned MAX_FRAMES    = 16;
  localparam int unsigned PAGE_BITS     = 16;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_REFS   = 1850;
  localparam int unsigned DRAIN_LIMIT   = 200;
  localparam int unsigned TAIL_CYCLES   = 24;
  localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR = '0;
  localparam logic [CFG_W-1:0] FRAME_SETTINGS [8] =
    '{5'd16, 5'd1, 5'd2, 5'd15, 5'd0, 5'd31, 5'd17, 5'd8};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [PAGE_W-1:0]      in_page_number;
  logic                   out_valid;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_index;
  logic [FAULT_W-1:0]     out_fault_count;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int                     mismatches;
  int                     pending;
  int unsigned            cycle_cnt = 0;
  int unsigned            refs_sent = 0;
  int unsigned            cfg_writes = 0;
  bit                     idling_on;

  fifo_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_frame_index(out_frame_index),
    .out_fault_count(out_fault_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  fifo_page_replacement_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) lookup_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_frame_index(out_frame_index),
    .out_fault_count(out_fault_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fifo_page_replacement: mismatch");
      $finish;
    end
  end

  // Present one reference and hold it until the block takes it
  task automatic send_page(input logic [PAGE_W-1:0] page);
    @(negedge clk);
    start          <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (busy);
    refs_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start          <= 1'b0;
      in_page_number <= $urandom();
    end
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(99) < 6) idle_cycles($urandom_range(1, 20));
  endtask

  // Drop start and hold until every result is back and the block is free
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Setup and access phase; upper data bits carry noise
  task automatic write_frames(input logic [CFG_W-1:0] count);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAMES_ADDR;
    pwdata  <= ($urandom() & ~32'((1 << CFG_W) - 1)) | 32'(count);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom();
    cfg_writes++;
  endtask

  // References drawn from a small working set, with some noise pages mixed in
  task automatic run_working_set(input logic [CFG_W-1:0] count, input int unsigned refs);
    logic [PAGE_W-1:0] pool [MAX_FRAMES + 4];
    int unsigned       n;
    int unsigned       pool_size;
    int unsigned       pause_at;
    settle();
    write_frames(count);
    n = (count == 0) ? 1 : (count > MAX_FRAMES) ? MAX_FRAMES : count;
    pool_size = $urandom_range(1, n + 4);
    pause_at  = $urandom_range(refs - 1);
    foreach (pool[i]) pool[i] = $urandom();
    for (int unsigned k = 0; k < refs; k++) begin
      if (k == pause_at) settle();
      if ($urandom_range(99) < 10) send_page($urandom());
      else send_page(pool[$urandom_range(pool_size - 1)]);
      maybe_idle();
    end
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       random_goal;
    int unsigned       waited;
    logic [CFG_W-1:0]  count;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idling_on      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Power-on frame count: page field extremes, hits on both
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hA5A5);
    // Zero frames acts as a single frame
    settle();
    write_frames(5'd0);
    send_page(16'h0001);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0001);
    settle();
    write_frames(5'd1);
    send_page(16'h5A5A);
    send_page(16'h5A5A);
    // Count above the frame limit saturates
    settle();
    write_frames(5'd31);
    send_page(16'h1234);
    send_page(16'h8000);
    send_page(16'h7FFF);
    send_page(16'h8000);
    // Pointer wraps on two frames
    settle();
    write_frames(5'd2);
    send_page(16'h0010);
    send_page(16'h0020);
    send_page(16'h0030);
    send_page(16'h0020);

    // Random working sets over a sweep of frame counts
    random_goal = refs_sent + RANDOM_REFS;
    phase = 0;
    while (refs_sent < random_goal) begin
      idling_on = (phase != 2);
      count = (phase < 8) ? FRAME_SETTINGS[phase] : CFG_W'($urandom_range(0, 31));
      run_working_set(count, $urandom_range(100, 260));
      phase++;
    end

    // Drain, then let the pipeline go quiet
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d page references over %0d frame-count writes (0, 1, 16 and above 16),",
             refs_sent, cfg_writes);
    $display("working-set hits, FIFO evictions and oldest-pointer wraps on each frame count.");
    if (mismatches == 0 && pending == 0) begin
      $display("fifo_page_replacement: match");
    end else begin
      $display("fifo_page_replacement: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fpr_pkg.sv
rtl/core/fpr_seq.sv
rtl/core/fpr_datapath.sv
rtl/core/fifo_page_replacement.sv
test/fifo_page_replacement_checker.sv
test/fifo_page_replacement_tb.sv
